### rtl/dles_pkg.sv
// ----------------------------------------------------------------------------
// dles_pkg
// Shared constants and types for the delta-list event scheduler.
// ----------------------------------------------------------------------------
package dles_pkg;

   // default configuration of the event table
   localparam int NUM_EVENTS_DEF = 16;
   localparam int IDLE_SLOT_DEF  = 15;

   // most expired events returned by one advance request
   localparam int MAX_RESULTS = 16;

   // idle period after reset
   localparam logic [30:0] IDLE_RESET_PERIOD = 31'h4000;

   // request opcodes
   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_CANCEL   = 2'd1;
   localparam logic [1:0] OP_ADVANCE  = 2'd2;

   // operand bundle for the shared adder
   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic        sub;
   } alu_req_type;

   // adder result with signed less-than flag
   typedef struct packed {
      logic [31:0] res;
      logic        lt;
   } alu_rsp_type;

endpackage

### rtl/dles_alu.sv
// ----------------------------------------------------------------------------
// dles_alu
// Shared 32-bit add/subtract unit with a signed less-than flag.
// ----------------------------------------------------------------------------
module dles_alu (
   input  dles_pkg::alu_req_type alu_req,
   output dles_pkg::alu_rsp_type alu_rsp
);
   import dles_pkg::*;

   logic [32:0] opb_ext;
   logic [32:0] sum_ext;

   // sign-extended add, or subtract through inverted operand and carry in
   assign opb_ext = alu_req.sub ? ~{alu_req.b[31], alu_req.b} : {alu_req.b[31], alu_req.b};
   assign sum_ext = {alu_req.a[31], alu_req.a} + opb_ext + {32'd0, alu_req.sub};

   assign alu_rsp.res = sum_ext[31:0];
   assign alu_rsp.lt  = alu_req.sub & sum_ext[32];

endmodule

### rtl/dles_mem.sv
// ----------------------------------------------------------------------------
// dles_mem
// Per-slot storage of relative delay and successor link, one registered read.
// ----------------------------------------------------------------------------
module dles_mem #(
   parameter  int NUM_EVENTS = dles_pkg::NUM_EVENTS_DEF,
   localparam int SLOT_W     = $clog2(NUM_EVENTS)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [31:0]       rd_delay,
   output logic [SLOT_W-1:0] rd_succ,
   input  logic              dly_we,
   input  logic [SLOT_W-1:0] dly_addr,
   input  logic [31:0]       dly_data,
   input  logic              succ_we,
   input  logic [SLOT_W-1:0] succ_addr,
   input  logic [SLOT_W-1:0] succ_data
);
   import dles_pkg::*;

   logic [31:0]       dly_mem  [NUM_EVENTS];
   logic [SLOT_W-1:0] succ_mem [NUM_EVENTS];
   logic [31:0]       rd_delay_ff;
   logic [SLOT_W-1:0] rd_succ_ff;

   // delay array
   always_ff @(posedge clock) begin
      if (dly_we) begin
         dly_mem[dly_addr] <= dly_data;
      end
      if (rd_en) begin
         rd_delay_ff <= dly_mem[rd_addr];
      end
   end

   // successor array
   always_ff @(posedge clock) begin
      if (succ_we) begin
         succ_mem[succ_addr] <= succ_data;
      end
      if (rd_en) begin
         rd_succ_ff <= succ_mem[rd_addr];
      end
   end

   assign rd_delay = rd_delay_ff;
   assign rd_succ  = rd_succ_ff;

endmodule

### rtl/delta_list_event_scheduler.sv
// ----------------------------------------------------------------------------
// delta_list_event_scheduler
// Time-ordered delta list of timed events with an idle sentinel kept last.
// ----------------------------------------------------------------------------
// One request is handled at a time and req_stall stays high until it is done.
// A small sequencer drives a single shared 32-bit adder and a delay and
// successor memory with one registered read port, one memory read or one add
// per cycle. An advance subtracts the elapsed time, then reads, pops and
// returns each expired event in turn (held while the response side stalls).
// A schedule walks the list entry by entry before inserting. A cancel of the
// head relinks it directly, else the list is walked to find the predecessor.
// Invalid or ignored requests leave the list unchanged.
// ----------------------------------------------------------------------------
module delta_list_event_scheduler #(
   parameter int NUM_EVENTS = dles_pkg::NUM_EVENTS_DEF,
   parameter int IDLE_SLOT  = dles_pkg::IDLE_SLOT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_op,
   input  logic [3:0]  req_event_id,
   input  logic [30:0] req_amount,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_fired_event,
   output logic        rsp_last,
   input  logic        csr_wr_en,
   input  logic [30:0] csr_wr_data
);
   import dles_pkg::*;

   localparam int SLOT_W  = $clog2(NUM_EVENTS);
   localparam int COUNT_W = $clog2(MAX_RESULTS);
   localparam logic [SLOT_W-1:0]  IDLE     = SLOT_W'(IDLE_SLOT);
   localparam logic [SLOT_W-1:0]  LAST_STP = SLOT_W'(NUM_EVENTS - 1);
   localparam logic [COUNT_W-1:0] LAST_CNT = COUNT_W'(MAX_RESULTS - 1);

   typedef enum logic [19:0] {
      ST_IDLE     = 20'h00001,
      ST_SCH_INIT = 20'h00002,
      ST_SCH_RD   = 20'h00004,
      ST_SCH_SUM  = 20'h00008,
      ST_SCH_CMP  = 20'h00010,
      ST_INS1     = 20'h00020,
      ST_INS2     = 20'h00040,
      ST_CAN_RD   = 20'h00080,
      ST_CAN_NXT  = 20'h00100,
      ST_CAN_ADD  = 20'h00200,
      ST_CAN_HD1  = 20'h00400,
      ST_CAN_HD2  = 20'h00800,
      ST_CAN_WRD  = 20'h01000,
      ST_CAN_WCHK = 20'h02000,
      ST_CAN_FIN  = 20'h04000,
      ST_ADV_SUB  = 20'h08000,
      ST_ADV_CHK  = 20'h10000,
      ST_ADV_RD   = 20'h20000,
      ST_ADV_POP  = 20'h40000,
      ST_ADV_ADD  = 20'h80000
   } state_type;

   state_type state_ff, state_in;

   logic [30:0]           idle_period_ff, idle_period_in;
   logic [31:0]           idle_delay_ff, idle_delay_in;
   logic [NUM_EVENTS-1:0] sched_ff, sched_in;
   logic [SLOT_W-1:0]     head_ff, head_in;
   logic [31:0]           countdown_ff, countdown_in;
   logic [31:0]           head_dur_ff, head_dur_in;

   logic [SLOT_W-1:0]     id_ff, id_in;
   logic [31:0]           amt_ff, amt_in;
   logic [SLOT_W-1:0]     cur_ff, cur_in;
   logic [SLOT_W-1:0]     prev_ff, prev_in;
   logic                  has_prev_ff, has_prev_in;
   logic [SLOT_W-1:0]     nxt_ff, nxt_in;
   logic [SLOT_W-1:0]     steps_ff, steps_in;
   logic [31:0]           running_ff, running_in;
   logic [31:0]           tmp_ff, tmp_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [SLOT_W-1:0]     ev_ff, ev_in;
   logic [SLOT_W-1:0]     rd_slot_ff, rd_slot_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [3:0]            rsp_event_ff, rsp_event_in;
   logic                  rsp_last_ff, rsp_last_in;

   alu_req_type           alu_req;
   alu_rsp_type           alu_rsp;

   logic                  rd_en;
   logic [SLOT_W-1:0]     rd_addr;
   logic [31:0]           mem_rd_delay;
   logic [SLOT_W-1:0]     mem_rd_succ;
   logic                  dly_we;
   logic [SLOT_W-1:0]     dly_addr;
   logic [31:0]           dly_data;
   logic                  succ_we;
   logic [SLOT_W-1:0]     succ_addr;
   logic [SLOT_W-1:0]     succ_data;

   logic [31:0]           rd_delay;
   logic                  out_free;
   logic                  sum_pos;
   logic                  req_ok;
   logic [SLOT_W-1:0]     req_slot;

   // shared adder
   dles_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   // slot storage; the idle slot delay lives in idle_delay_ff
   dles_mem #(
      .NUM_EVENTS (NUM_EVENTS)
   ) u_mem (
      .clock     (clock),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .rd_delay  (mem_rd_delay),
      .rd_succ   (mem_rd_succ),
      .dly_we    (dly_we && (dly_addr != IDLE)),
      .dly_addr  (dly_addr),
      .dly_data  (dly_data),
      .succ_we   (succ_we),
      .succ_addr (succ_addr),
      .succ_data (succ_data)
   );

   // delay of the last slot read, idle slot from its register
   assign rd_delay = (rd_slot_ff == IDLE) ? idle_delay_ff : mem_rd_delay;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign sum_pos  = (alu_rsp.res != 32'd0) && !alu_rsp.res[31];

   // request slot range check
   assign req_slot = SLOT_W'(req_event_id);
   assign req_ok   = (32'(req_event_id) < NUM_EVENTS) && (req_slot != IDLE);

   // sequencer
   always_comb begin
      state_in       = state_ff;
      idle_period_in = idle_period_ff;
      idle_delay_in  = idle_delay_ff;
      sched_in       = sched_ff;
      head_in        = head_ff;
      countdown_in   = countdown_ff;
      head_dur_in    = head_dur_ff;
      id_in          = id_ff;
      amt_in         = amt_ff;
      cur_in         = cur_ff;
      prev_in        = prev_ff;
      has_prev_in    = has_prev_ff;
      nxt_in         = nxt_ff;
      steps_in       = steps_ff;
      running_in     = running_ff;
      tmp_in         = tmp_ff;
      count_in       = count_ff;
      ev_in          = ev_ff;
      rd_slot_in     = rd_slot_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_event_in   = rsp_event_ff;
      rsp_last_in    = rsp_last_ff;
      alu_req        = '{a: countdown_ff, b: head_dur_ff, sub: 1'b1};
      rd_en          = 1'b0;
      rd_addr        = cur_ff;
      dly_we         = 1'b0;
      dly_addr       = id_ff;
      dly_data       = tmp_ff;
      succ_we        = 1'b0;
      succ_addr      = id_ff;
      succ_data      = cur_ff;

      if (csr_wr_en) begin
         idle_period_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               id_in  = req_slot;
               amt_in = {1'b0, req_amount};
               case (req_op)
                  OP_SCHEDULE: begin
                     if (req_ok && !sched_ff[req_slot]) begin
                        state_in = ST_SCH_INIT;
                     end
                  end
                  OP_CANCEL: begin
                     if (req_ok && sched_ff[req_slot]) begin
                        state_in = ST_CAN_RD;
                     end
                  end
                  OP_ADVANCE: begin
                     state_in = ST_ADV_SUB;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // schedule: running = countdown - head_duration
         ST_SCH_INIT: begin
            running_in  = alu_rsp.res;
            cur_in      = head_ff;
            has_prev_in = 1'b0;
            steps_in    = '0;
            state_in    = ST_SCH_RD;
         end
         ST_SCH_RD: begin
            rd_en      = 1'b1;
            rd_slot_in = cur_ff;
            state_in   = ST_SCH_SUM;
         end
         ST_SCH_SUM: begin
            alu_req = '{a: running_ff, b: rd_delay, sub: 1'b0};
            tmp_in  = alu_rsp.res;
            if (cur_ff == IDLE || steps_ff == LAST_STP) begin
               state_in = ST_INS1;
            end else begin
               state_in = ST_SCH_CMP;
            end
         end
         // insert here when running + delay > t
         ST_SCH_CMP: begin
            alu_req = '{a: amt_ff, b: tmp_ff, sub: 1'b1};
            if (alu_rsp.lt) begin
               state_in = ST_INS1;
            end else begin
               running_in  = tmp_ff;
               prev_in     = cur_ff;
               has_prev_in = 1'b1;
               cur_in      = mem_rd_succ;
               steps_in    = steps_ff + 1'b1;
               state_in    = ST_SCH_RD;
            end
         end
         // new entry: delay t - running, linked ahead of cur
         ST_INS1: begin
            alu_req   = '{a: amt_ff, b: running_ff, sub: 1'b1};
            tmp_in    = alu_rsp.res;
            dly_we    = 1'b1;
            dly_addr  = id_ff;
            dly_data  = alu_rsp.res;
            succ_we   = 1'b1;
            succ_addr = id_ff;
            succ_data = cur_ff;
            state_in  = ST_INS2;
         end
         ST_INS2: begin
            alu_req  = '{a: rd_delay, b: tmp_ff, sub: 1'b1};
            dly_we   = 1'b1;
            dly_addr = cur_ff;
            dly_data = alu_rsp.res;
            if (!has_prev_ff) begin
               head_in      = id_ff;
               head_dur_in  = tmp_ff;
               countdown_in = amt_ff;
            end else begin
               succ_we   = 1'b1;
               succ_addr = prev_ff;
               succ_data = id_ff;
            end
            sched_in[id_ff] = 1'b1;
            idle_delay_in   = {1'b0, idle_period_ff};
            state_in        = ST_IDLE;
         end

         // cancel: fetch the entry and its successor
         ST_CAN_RD: begin
            rd_en      = 1'b1;
            rd_addr    = id_ff;
            rd_slot_in = id_ff;
            state_in   = ST_CAN_NXT;
         end
         ST_CAN_NXT: begin
            tmp_in     = rd_delay;
            nxt_in     = mem_rd_succ;
            rd_en      = 1'b1;
            rd_addr    = mem_rd_succ;
            rd_slot_in = mem_rd_succ;
            state_in   = ST_CAN_ADD;
         end
         ST_CAN_ADD: begin
            alu_req  = '{a: rd_delay, b: tmp_ff, sub: 1'b0};
            tmp_in   = alu_rsp.res;
            dly_we   = 1'b1;
            dly_addr = nxt_ff;
            dly_data = alu_rsp.res;
            if (head_ff == id_ff) begin
               state_in = ST_CAN_HD1;
            end else begin
               cur_in   = head_ff;
               steps_in = '0;
               state_in = ST_CAN_WRD;
            end
         end
         // head removed: keep the elapsed part of the old head
         ST_CAN_HD1: begin
            alu_req    = '{a: head_dur_ff, b: countdown_ff, sub: 1'b1};
            running_in = alu_rsp.res;
            state_in   = ST_CAN_HD2;
         end
         ST_CAN_HD2: begin
            alu_req      = '{a: tmp_ff, b: running_ff, sub: 1'b1};
            countdown_in = alu_rsp.res;
            head_in      = nxt_ff;
            head_dur_in  = tmp_ff;
            state_in     = ST_CAN_FIN;
         end
         // find the predecessor and relink it
         ST_CAN_WRD: begin
            rd_en      = 1'b1;
            rd_slot_in = cur_ff;
            state_in   = ST_CAN_WCHK;
         end
         ST_CAN_WCHK: begin
            if (mem_rd_succ == id_ff) begin
               succ_we   = 1'b1;
               succ_addr = cur_ff;
               succ_data = nxt_ff;
               state_in  = ST_CAN_FIN;
            end else if (cur_ff == IDLE || steps_ff == LAST_STP) begin
               state_in = ST_CAN_FIN;
            end else begin
               cur_in   = mem_rd_succ;
               steps_in = steps_ff + 1'b1;
               state_in = ST_CAN_WRD;
            end
         end
         ST_CAN_FIN: begin
            sched_in[id_ff] = 1'b0;
            idle_delay_in   = {1'b0, idle_period_ff};
            state_in        = ST_IDLE;
         end

         // advance: countdown -= elapsed
         ST_ADV_SUB: begin
            alu_req      = '{a: countdown_ff, b: amt_ff, sub: 1'b1};
            countdown_in = alu_rsp.res;
            state_in     = ST_ADV_CHK;
         end
         ST_ADV_CHK: begin
            count_in = '0;
            if (countdown_ff != 32'd0 && !countdown_ff[31]) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_ADV_RD;
            end
         end
         ST_ADV_RD: begin
            rd_en      = 1'b1;
            rd_addr    = head_ff;
            rd_slot_in = head_ff;
            state_in   = ST_ADV_POP;
         end
         // pop the head, fetch the new head delay
         ST_ADV_POP: begin
            ev_in = head_ff;
            if (head_ff == IDLE) begin
               idle_delay_in = {1'b0, idle_period_ff};
               head_in       = IDLE;
               rd_addr       = IDLE;
               rd_slot_in    = IDLE;
            end else begin
               sched_in[head_ff] = 1'b0;
               head_in           = mem_rd_succ;
               rd_addr           = mem_rd_succ;
               rd_slot_in        = mem_rd_succ;
            end
            rd_en    = 1'b1;
            state_in = ST_ADV_ADD;
         end
         // new countdown, then send the fired event
         ST_ADV_ADD: begin
            alu_req = '{a: countdown_ff, b: rd_delay, sub: 1'b0};
            if (out_free) begin
               countdown_in = alu_rsp.res;
               head_dur_in  = rd_delay;
               count_in     = count_ff + 1'b1;
               rsp_valid_in = 1'b1;
               rsp_event_in = 4'(ev_ff);
               rsp_last_in  = sum_pos || (count_ff == LAST_CNT);
               if (sum_pos || count_ff == LAST_CNT) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_ADV_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         idle_period_ff <= IDLE_RESET_PERIOD;
         idle_delay_ff  <= {1'b0, IDLE_RESET_PERIOD};
         sched_ff       <= NUM_EVENTS'(1) << IDLE_SLOT;
         head_ff        <= IDLE;
         countdown_ff   <= '0;
         head_dur_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         idle_period_ff <= idle_period_in;
         idle_delay_ff  <= idle_delay_in;
         sched_ff       <= sched_in;
         head_ff        <= head_in;
         countdown_ff   <= countdown_in;
         head_dur_ff    <= head_dur_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      id_ff        <= id_in;
      amt_ff       <= amt_in;
      cur_ff       <= cur_in;
      prev_ff      <= prev_in;
      has_prev_ff  <= has_prev_in;
      nxt_ff       <= nxt_in;
      steps_ff     <= steps_in;
      running_ff   <= running_in;
      tmp_ff       <= tmp_in;
      count_ff     <= count_in;
      ev_ff        <= ev_in;
      rd_slot_ff   <= rd_slot_in;
      rsp_event_ff <= rsp_event_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_fired_event = rsp_event_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
